// ----- rtl/stir2_pkg.sv -----
// ----------------------------------------------------------------------------
// stir2_pkg
// Shared types and constants of the Stirling second-kind counter: widths,
// the overflow code of a row cell, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package stir2_pkg;

  // Largest set size the row memory holds
  localparam int MAX_SET_SIZE = 63;
  localparam int ROW_DEPTH    = MAX_SET_SIZE + 1;
  localparam int IDX_W        = $clog2(ROW_DEPTH);

  // Field widths
  localparam int N_W    = 6;
  localparam int WAYS_W = 63;
  // A row cell carries one more bit: the value 2^63 marks an overflowed cell
  localparam int CELL_W = WAYS_W + 1;
  // Column index times cell value
  localparam int MUL_W  = WAYS_W + IDX_W;

  localparam logic [WAYS_W-1:0] WAYS_MAX = {WAYS_W{1'b1}};
  localparam logic [CELL_W-1:0] CELL_OVF = {1'b1, {WAYS_W{1'b0}}};
  localparam logic [CELL_W-1:0] CELL_ONE = CELL_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EMPTY,
    S_READ,
    S_MUL,
    S_WRITE,
    S_FETCH,
    S_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the query, start at row 1, column 1
    logic rd_cell;   // read the current and left-hand cells
    logic do_mul;    // register column times cell
    logic do_wr;     // add and write the current cell
    logic step_col;  // move one column left
    logic step_row;  // next row, column at its top
    logic rd_res;    // read the result cell
    logic out_zero;  // load a zero result
    logic out_load;  // load the result cell
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic trivial;     // result is zero without any work
    logic col_is_one;  // current column is the first
    logic row_is_last; // current row is the set size
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

// ----- rtl/stir2_ctrl.sv -----
// ----------------------------------------------------------------------------
// stir2_ctrl
// Sequencer of the counter: walks the rows and the columns of the triangle,
// reading, multiplying and writing back each cell, then fetches and hands over the result.
// ----------------------------------------------------------------------------
module stir2_ctrl
  import stir2_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.trivial ? S_EMPTY : S_READ;
      end
      S_EMPTY: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_READ:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_WRITE;
      S_WRITE: begin
        if (sts.col_is_one && sts.row_is_last) state_nxt = S_FETCH;
        else                                   state_nxt = S_READ;
      end
      S_FETCH: state_nxt = S_RESULT;
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EMPTY:  cmd.out_zero = sts.out_free;
      S_READ:   cmd.rd_cell  = 1'b1;
      S_MUL:    cmd.do_mul   = 1'b1;
      S_WRITE: begin
        cmd.do_wr    = 1'b1;
        cmd.step_col = !sts.col_is_one;
        cmd.step_row = sts.col_is_one && !sts.row_is_last;
      end
      S_FETCH:  cmd.rd_res   = 1'b1;
      S_RESULT: cmd.out_load = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/stir2_dp.sv -----
// ----------------------------------------------------------------------------
// stir2_dp
// Datapath of the counter: query and index registers, the row memory, the
// shared multiply-add with overflow tracking, and the output register.
// ----------------------------------------------------------------------------
module stir2_dp
  import stir2_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [N_W-1:0]    set_size,
  input  logic [N_W-1:0]    part_count,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WAYS_W-1:0] ways,
  output logic              overflow
);

  logic [N_W-1:0]    n_r, k_r;
  logic [IDX_W-1:0]  i_r, j_r, i_nxt, top_nxt;
  logic              one_r, ovf_r;
  logic [CELL_W-1:0] a_r, b_r, cell_nxt;
  logic [MUL_W-1:0]  prod_r;
  logic [CELL_W-1:0] sum;
  logic [IDX_W-1:0]  rd_addr;
  logic [WAYS_W-1:0] ways_r;
  logic              flag_r, valid_r;

  logic [CELL_W-1:0] row_mem [ROW_DEPTH];

  // Row and column sequencing
  assign i_nxt   = i_r + IDX_W'(1);
  assign top_nxt = (i_nxt < IDX_W'(k_r)) ? i_nxt : IDX_W'(k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.load) begin
      i_r <= IDX_W'(1);
      j_r <= IDX_W'(1);
    end else if (cmd.step_row) begin
      i_r <= i_nxt;
      j_r <= top_nxt;
    end else if (cmd.step_col) begin
      j_r <= j_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= set_size;
      k_r <= part_count;
    end
  end

  assign sts.trivial     = (n_r == '0) || (k_r == '0) || (k_r > n_r);
  assign sts.col_is_one  = (j_r == IDX_W'(1));
  assign sts.row_is_last = (i_r == IDX_W'(n_r));
  assign sts.out_free    = !valid_r || out_ready;

  // Row memory: one write port, two registered read ports
  assign rd_addr = cmd.rd_res ? IDX_W'(k_r) : j_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_cell || cmd.rd_res) begin
      a_r   <= row_mem[rd_addr];
      b_r   <= row_mem[j_r - IDX_W'(1)];
      one_r <= (j_r == IDX_W'(1)) || (j_r == i_r);
    end
    if (cmd.do_wr) begin
      row_mem[j_r] <= cell_nxt;
    end
  end

  // Multiply stage: column times the cell above
  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      prod_r <= MUL_W'(j_r) * MUL_W'(a_r[WAYS_W-1:0]);
      ovf_r  <= a_r[CELL_W-1] || b_r[CELL_W-1];
    end
  end

  // Add stage: one on column 1 or the diagonal, else saturate to the overflow code
  assign sum = CELL_W'(prod_r[WAYS_W-1:0]) + CELL_W'(b_r[WAYS_W-1:0]);

  always_comb begin
    if (one_r) begin
      cell_nxt = CELL_ONE;
    end else if (ovf_r || (prod_r[MUL_W-1:WAYS_W] != '0) || sum[CELL_W-1]) begin
      cell_nxt = CELL_OVF;
    end else begin
      cell_nxt = sum;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.out_zero || cmd.out_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_zero) begin
      ways_r <= '0;
      flag_r <= 1'b0;
    end else if (cmd.out_load) begin
      ways_r <= a_r[CELL_W-1] ? WAYS_MAX : a_r[WAYS_W-1:0];
      flag_r <= a_r[CELL_W-1];
    end
  end

  assign out_valid = valid_r;
  assign ways      = ways_r;
  assign overflow  = flag_r;

endmodule

// ----- rtl/stirling_second_kind_counter.sv -----
// ----------------------------------------------------------------------------
// stirling_second_kind_counter
// Computes S(n,k), the Stirling number of the second kind, one query at a time.
//
// Usage:
//   Input channel (in_*): one item is a query, set size n and part count k.
//   Output channel (out_*): one item per query, the count S(n,k) in out_tdata
//   and the overflow flag in out_tuser. A count above 2^63-1 saturates to
//   2^63-1 with the flag set.
//   The block works one query at a time: in_tready is high only while idle.
//   A trivial query (n or k zero, or k above n) returns zero without visiting
//   the triangle. Otherwise the shared multiply-add visits every cell of the
//   triangle up to row n and column k in turn (read, multiply, add and write
//   back to the row memory), and then the result cell is fetched.
//   A new query is taken only once the last result is in the output register.
//   The result sits in an output register; while the receiver stalls, the
//   block holds it and the next query's result waits in its last state.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any pending result. The row memory needs no clearing: each query writes
//   every cell before it uses the cell's value.
// ----------------------------------------------------------------------------
module stirling_second_kind_counter
  import stir2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] set_size, [11:6] part_count, [15:12] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [62:0] ways, [63] zero
  output logic        out_tuser   // [0] overflow
);

  cmd_t              cmd;
  sts_t              sts;
  logic [WAYS_W-1:0] ways;

  // Sequencer
  stir2_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Row memory, multiply-add and output register
  stir2_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .set_size   (in_tdata[N_W-1:0]),
    .part_count (in_tdata[2*N_W-1:N_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .ways       (ways),
    .overflow   (out_tuser)
  );

  assign out_tdata = {1'b0, ways};

  // Only one datapath action per cycle
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd_cell, cmd.do_mul, cmd.do_wr, cmd.rd_res,
              cmd.out_zero, cmd.out_load}))
    else $error("more than one datapath action in a cycle");

  // A saturated result carries the maximum count
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[WAYS_W-1:0] == WAYS_MAX))
    else $error("overflow flag without saturated count");

  // One query at a time: no acceptance in the cycle after an acceptance
  a_one_query: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("query accepted while busy");

endmodule
